// ===== rtl/core/mwmh_pkg.sv =====
// Package for the multi-word mix hash: word slot names, the mix round
// schedule for each word count, shift amounts and the pipeline stage type.
// No dependencies.
package mwmh_pkg;

  localparam logic [31:0] SEED = 32'd1315423911;
  localparam logic [31:0] K1   = 32'd231232;
  localparam logic [31:0] K2   = 32'd1232;

  localparam int unsigned NUM_ROUNDS = 8;
  localparam int unsigned NUM_STEPS  = 9;
  localparam int unsigned NUM_CELLS  = NUM_ROUNDS * NUM_STEPS;

  // Opcode values: word count minus one.
  localparam logic [2:0] OP_ONE   = 3'd0;
  localparam logic [2:0] OP_TWO   = 3'd1;
  localparam logic [2:0] OP_THREE = 3'd2;
  localparam logic [2:0] OP_FOUR  = 3'd3;
  localparam logic [2:0] OP_FIVE  = 3'd4;

  // Working word slots carried down the pipeline.
  typedef enum logic [2:0] {W_A, W_B, W_C, W_D, W_E, W_X, W_Y, W_H} word_idx_t;

  // One mix round: enable, first and second operand slots (the hash is third).
  typedef struct packed {
    logic      en;
    word_idx_t p;
    word_idx_t q;
  } mix_sel_t;

  localparam mix_sel_t NOP = '{1'b0, W_A, W_A};

  localparam mix_sel_t SCHED_1 [NUM_ROUNDS] = '{
    '{1'b1, W_B, W_X}, '{1'b1, W_Y, W_A}, NOP, NOP, NOP, NOP, NOP, NOP};
  localparam mix_sel_t SCHED_2 [NUM_ROUNDS] = '{
    '{1'b1, W_A, W_B}, '{1'b1, W_X, W_A}, '{1'b1, W_B, W_Y},
    NOP, NOP, NOP, NOP, NOP};
  localparam mix_sel_t SCHED_3 [NUM_ROUNDS] = '{
    '{1'b1, W_A, W_B}, '{1'b1, W_C, W_X}, '{1'b1, W_Y, W_A},
    '{1'b1, W_B, W_X}, '{1'b1, W_Y, W_C}, NOP, NOP, NOP};
  localparam mix_sel_t SCHED_4 [NUM_ROUNDS] = '{
    '{1'b1, W_A, W_B}, '{1'b1, W_C, W_D}, '{1'b1, W_A, W_X},
    '{1'b1, W_Y, W_B}, '{1'b1, W_C, W_X}, '{1'b1, W_Y, W_D}, NOP, NOP};
  localparam mix_sel_t SCHED_5 [NUM_ROUNDS] = '{
    '{1'b1, W_A, W_B}, '{1'b1, W_C, W_D}, '{1'b1, W_E, W_X},
    '{1'b1, W_Y, W_A}, '{1'b1, W_B, W_X}, '{1'b1, W_Y, W_C},
    '{1'b1, W_D, W_X}, '{1'b1, W_Y, W_E}};

  // Shift amount of each step of a round; every third step, starting at
  // the second, shifts left.
  localparam int unsigned STEP_SHIFT [NUM_STEPS] = '{13, 8, 13, 12, 16, 5, 3, 10, 15};

  // Item as it travels down the chain of cells.
  typedef struct packed {
    logic             valid;
    logic [2:0]       opcode;
    logic             zero;
    logic [7:0][31:0] words;
  } stage_t;

  // Round selection for a given word count; an unknown opcode mixes nothing.
  function automatic mix_sel_t sched_sel(logic [2:0] opcode, int unsigned rnd);
    mix_sel_t s;
    s = NOP;
    case (opcode)
      OP_ONE:   s = SCHED_1[rnd];
      OP_TWO:   s = SCHED_2[rnd];
      OP_THREE: s = SCHED_3[rnd];
      OP_FOUR:  s = SCHED_4[rnd];
      OP_FIVE:  s = SCHED_5[rnd];
      default:  s = NOP;
    endcase
    return s;
  endfunction

  // Slot that plays a given role (0: first, 1: second, 2: hash) in a round.
  function automatic word_idx_t role_word(mix_sel_t s, int unsigned role);
    word_idx_t w;
    case (role)
      0:       w = s.p;
      1:       w = s.q;
      default: w = W_H;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/mwmh_if.sv =====
// Handshake channel interfaces for the multi-word mix hash.
// No dependencies.
interface mwmh_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  hash_type;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [31:0] word_d;
  logic [31:0] word_e;

  modport source (output valid, opcode, hash_type, word_a, word_b, word_c, word_d, word_e,
                  input ready);
  modport sink (input valid, opcode, hash_type, word_a, word_b, word_c, word_d, word_e,
                output ready);
endinterface

interface mwmh_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

// ===== rtl/core/mwmh_load.sv =====
// Entry stage: forms the seeded hash and the working word slots of an item.
// Depends on mwmh_pkg.
module mwmh_load import mwmh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        take,
  input  logic [2:0]  opcode,
  input  logic [7:0]  hash_type,
  input  logic [31:0] word_a,
  input  logic [31:0] word_b,
  input  logic [31:0] word_c,
  input  logic [31:0] word_d,
  input  logic [31:0] word_e,
  output stage_t      q
);

  stage_t q_next;
  logic [31:0] sb, sc, sd, se;

  // Words past the selected count do not enter the seed.
  always_comb begin
    sb = (opcode >= OP_TWO   && opcode <= OP_FIVE) ? word_b : '0;
    sc = (opcode >= OP_THREE && opcode <= OP_FIVE) ? word_c : '0;
    sd = (opcode >= OP_FOUR  && opcode <= OP_FIVE) ? word_d : '0;
    se = (opcode == OP_FIVE) ? word_e : '0;
  end

  // A single word is mixed twice, so its copy takes the second slot.
  always_comb begin
    q_next.valid     = take;
    q_next.opcode    = opcode;
    q_next.zero      = (hash_type != 8'd0) || (opcode > OP_FIVE);
    q_next.words[W_A] = word_a;
    q_next.words[W_B] = (opcode == OP_ONE) ? word_a : word_b;
    q_next.words[W_C] = word_c;
    q_next.words[W_D] = word_d;
    q_next.words[W_E] = word_e;
    q_next.words[W_X] = K1;
    q_next.words[W_Y] = K2;
    q_next.words[W_H] = SEED ^ word_a ^ sb ^ sc ^ sd ^ se;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/mwmh_cell.sv =====
// One cell of the mixing chain: a single subtract-subtract-xor step of a
// mix round, followed by the stage register. Depends on mwmh_pkg.
module mwmh_cell import mwmh_pkg::*; #(
  parameter int unsigned ROUND = 0,
  parameter int unsigned STEP  = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  stage_t d,
  output stage_t q
);

  localparam int unsigned ROLE_T = STEP % 3;
  localparam int unsigned ROLE_U = (STEP + 1) % 3;
  localparam int unsigned ROLE_V = (STEP + 2) % 3;
  localparam int unsigned SH     = STEP_SHIFT[STEP];
  localparam bit          LEFT   = (STEP % 3) == 1;

  mix_sel_t    sel;
  word_idx_t   ti, ui, vi;
  logic [31:0] tv, uv, vv, shv, newv;
  stage_t      q_next;

  // Operand slots for this round and word count.
  always_comb begin
    sel = sched_sel(d.opcode, ROUND);
    ti  = role_word(sel, ROLE_T);
    ui  = role_word(sel, ROLE_U);
    vi  = role_word(sel, ROLE_V);
    tv  = d.words[ti];
    uv  = d.words[ui];
    vv  = d.words[vi];
  end

  // The step itself, all arithmetic wrapping at 32 bits.
  always_comb begin
    shv  = LEFT ? (vv << SH) : (vv >> SH);
    newv = (tv - uv - vv) ^ shv;
  end

  // Rounds not used by this word count pass the item through.
  always_comb begin
    q_next = d;
    if (sel.en) begin
      q_next.words[ti] = newv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/mwmh_out_buf.sv =====
// Two-entry result queue at the end of the chain; the chain advances
// whenever it has room. Depends on mwmh_pkg and mwmh_if.
module mwmh_out_buf import mwmh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] value,
  output logic        room,
  mwmh_rsp_if.source  rsp
);

  logic [31:0] data [2];
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        wr_ptr;
  logic        rd_ptr;
  logic        pop;

  assign pop  = rsp.valid && rsp.ready;
  assign room = (count != 2'd2);

  assign rsp.valid      = (count != 2'd0);
  assign rsp.hash_value = data[rd_ptr];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (!push && pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      data[wr_ptr] <= value;
    end
  end

  // The queue never overfills and its pointers track the occupancy.
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result queue count out of range");
  assert property (@(posedge clk) disable iff (rst) push |-> room)
    else $error("push into a full result queue");
  assert property (@(posedge clk) disable iff (rst)
                   (count == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with count");
  assert property (@(posedge clk) disable iff (rst)
                   ((count == 2'd0) || (count == 2'd2)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/core/multi_word_mix_hash32.sv =====
// Top level of the multi-word mix hash: entry stage, chain of 72 mixing
// cells (eight rounds of nine steps) and the result queue.
// Depends on mwmh_pkg, mwmh_if, mwmh_load, mwmh_cell and mwmh_out_buf.
//
//   Port  Dir  Payload                                               Accepted when
//   req   in   opcode, hash_type, word_a, word_b, word_c, word_d, word_e  valid & ready
//   rsp   out  hash_value                                            valid & ready
//
// One item is taken per cycle while the result queue has room. The entry stage
// loads an item on the edge that accepts it; its result then passes through 72 cells,
// each doing one step of a round, and is written to the result queue for rsp.
// The whole chain advances together while the two-entry result queue has room;
// when it is full the chain and req.ready hold until rsp takes a result.
// Reset (rst, synchronous) empties the chain and the queue.
module multi_word_mix_hash32 import mwmh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mwmh_req_if.sink   req,
  mwmh_rsp_if.source rsp
);

  stage_t chain [NUM_CELLS + 1];
  logic   en;
  logic   take;
  logic   push;
  logic [31:0] value;

  assign req.ready = en;
  assign take      = req.valid && en;

  // Entry stage.
  mwmh_load u_load (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .take      (take),
    .opcode    (req.opcode),
    .hash_type (req.hash_type),
    .word_a    (req.word_a),
    .word_b    (req.word_b),
    .word_c    (req.word_c),
    .word_d    (req.word_d),
    .word_e    (req.word_e),
    .q         (chain[0])
  );

  // Chain of mixing cells, round by round.
  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
      mwmh_cell #(
        .ROUND (r),
        .STEP  (s)
      ) u_cell (
        .clk (clk),
        .rst (rst),
        .en  (en),
        .d   (chain[r * NUM_STEPS + s]),
        .q   (chain[r * NUM_STEPS + s + 1])
      );
    end
  end

  // Unknown hash kinds and word counts give zero.
  assign push  = en && chain[NUM_CELLS].valid;
  assign value = chain[NUM_CELLS].zero ? 32'd0 : chain[NUM_CELLS].words[W_H];

  mwmh_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .value (value),
    .room  (en),
    .rsp   (rsp)
  );

  // A stalled chain holds its last item, and an accepted item enters it.
  assert property (@(posedge clk) disable iff (rst) !en |=> $stable(chain[NUM_CELLS]))
    else $error("last cell changed during a stall");
  assert property (@(posedge clk) disable iff (rst) take |=> chain[0].valid)
    else $error("accepted item missing from entry stage");
  assert property (@(posedge clk) disable iff (rst)
                   (en && !req.valid) |=> !chain[0].valid)
    else $error("entry stage holds an item that was not accepted");

endmodule
